### rtl/core/stu_pkg.sv
// ----------------------------------------------------------------------------
// stu_pkg
// Shared types and constants of the stereo upsampler to bus rate.
// ----------------------------------------------------------------------------
package stu_pkg;

   localparam int SAMPLE_W = 16;
   localparam int PHASE_W  = 16;

   localparam logic [17:0] PHASE_ONE        = 18'd65536;
   localparam logic [15:0] PHASE_STEP_RESET = 16'd60211;
   // ceil(2^17 / 3), exact truncation for magnitudes below 2^17
   localparam logic [17:0] DIV3_RECIP       = 18'd43691;

   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_X3   = 2'd1,
      MODE_X2   = 2'd2,
      MODE_FRAC = 2'd3
   } rate_mode_type;

   typedef enum logic {
      CSR_RATE_MODE  = 1'b0,
      CSR_PHASE_STEP = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_FRAME = 1'b0,
      REQ_FLUSH = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      OP_PASS = 2'd0,
      OP_DIV3 = 2'd1,
      OP_FRAC = 2'd2
   } lane_op_type;

   typedef struct packed {
      rate_mode_type        mode;
      logic [1:0]           idx;
      logic [PHASE_W-1:0]   frac;
   } issue_type;

endpackage

### rtl/core/stu_lane.sv
// ----------------------------------------------------------------------------
// stu_lane
// One channel of the interpolator: operand select and multiply, then add.
// ----------------------------------------------------------------------------
module stu_lane
   import stu_pkg::*;
(
   input  logic                        clock,
   input  logic                        load,
   input  issue_type                   issue,
   input  logic signed [SAMPLE_W-1:0]  prev,
   input  logic signed [SAMPLE_W-1:0]  cur,
   output logic signed [SAMPLE_W-1:0]  value
);

   logic signed [16:0] diff;
   logic signed [17:0] step_x;
   logic [17:0]        mag;
   logic               neg;
   logic signed [16:0] sum;
   logic signed [16:0] sum_rnd;
   logic signed [17:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [35:0] product;
   lane_op_type        op;
   logic [15:0]        base;

   lane_op_type        op_ff;
   logic [15:0]        base_ff;
   logic               neg_ff;
   logic [16:0]        prod_ff;
   logic [15:0]        quot;

   always_comb begin
      diff    = {prev[15], prev} ;
      diff    = {cur[15], cur} - diff;
      step_x  = (issue.idx == 2'd1) ? {diff[16], diff} : {diff, 1'b0};
      neg     = step_x[17];
      mag     = neg ? 18'(-step_x) : 18'(step_x);
      sum     = {prev[15], prev} + {cur[15], cur};
      sum_rnd = sum + 17'(sum[16]);
      op      = OP_PASS;
      base    = cur;
      mul_a   = '0;
      mul_b   = '0;
      unique case (issue.mode)
         MODE_PASS: begin
            op   = OP_PASS;
            base = cur;
         end
         MODE_X3: begin
            base = prev;
            if (issue.idx == 2'd0) begin
               op = OP_PASS;
            end else begin
               op    = OP_DIV3;
               mul_a = {1'b0, mag[16:0]};
               mul_b = DIV3_RECIP;
            end
         end
         MODE_X2: begin
            op   = OP_PASS;
            base = (issue.idx == 2'd0) ? prev : sum_rnd[16:1];
         end
         MODE_FRAC: begin
            op    = OP_FRAC;
            base  = prev;
            mul_a = {diff[16], diff};
            mul_b = {2'b00, issue.frac};
         end
      endcase
      product = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff   <= op;
         base_ff <= base;
         neg_ff  <= neg;
         prod_ff <= product[32:16];
      end
   end

   always_comb begin
      quot = prod_ff[16:1];
      unique case (op_ff)
         OP_DIV3: value = neg_ff ? signed'(base_ff - quot) : signed'(base_ff + quot);
         OP_FRAC: value = signed'(base_ff + prod_ff[15:0]);
         default: value = signed'(base_ff);
      endcase
   end

endmodule

### rtl/core/stu_merge.sv
// ----------------------------------------------------------------------------
// stu_merge
// Joins the two lane results into one frame and holds it for the bus.
// ----------------------------------------------------------------------------
module stu_merge
   import stu_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        a_valid,
   input  logic                        a_last,
   input  logic signed [SAMPLE_W-1:0]  left,
   input  logic signed [SAMPLE_W-1:0]  right,
   output logic                        out_adv,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // out_left, out_right
   output logic                        rsp_tlast
);

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] data_ff;
   logic        last_ff;

   assign out_adv  = !valid_ff || rsp_tready;
   assign valid_in = out_adv ? a_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         data_ff <= {right, left};
         last_ff <= a_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

### rtl/core/stereo_upsampler_to_bus_rate.sv
// ----------------------------------------------------------------------------
// stereo_upsampler_to_bus_rate
// Stereo frame upsampler: passthrough, x3, x2 and fractional phase modes.
// Results pass the sequencer, lane and output registers, then leave one per
// cycle while rsp_tready holds. An item yields 1 to 3 results, a flush none,
// from the result sequencer feeding both lanes one frame per cycle unstalled.
// Synchronous reset clears all history, phase and mode; phase_step to 60211.
// ----------------------------------------------------------------------------
module stereo_upsampler_to_bus_rate
   import stu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // in_left, in_right
   input  logic [1:0]   req_tuser,   // req_type, first_of_call
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // out_left, out_right
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [15:0]  csr_wdata
);

   rate_mode_type      rate_mode_ff;
   logic [15:0]        phase_step_ff;

   logic signed [15:0] int_prev_l_ff, int_prev_r_ff, int_prev_l_in, int_prev_r_in;
   logic signed [15:0] frac_prev_l_ff, frac_prev_r_ff, frac_prev_l_in, frac_prev_r_in;
   logic [15:0]        frac_phase_ff, frac_phase_in;

   rate_mode_type      mode_ff, mode_in;
   logic signed [15:0] prev_l_ff, prev_r_ff, cur_l_ff, cur_r_ff;
   logic signed [15:0] prev_l_in, prev_r_in;
   logic [15:0]        step_ff;
   logic [15:0]        frac_ff, frac_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [1:0]         idx_ff, idx_in;
   logic               a_vld_ff, a_vld_in;
   logic               a_last_ff, a_last_in;

   logic               accept;
   logic               is_flush;
   logic               out_adv;
   logic               a_free;
   logic               issue_go;
   logic signed [15:0] in_l, in_r;
   logic [17:0]        ph0, st, ph1, ph2, ph3;
   logic [1:0]         frac_cnt;
   logic [15:0]        frac_next;
   issue_type          issue;
   logic signed [15:0] lane_l, lane_r;

   assign in_l     = signed'(req_tdata[15:0]);
   assign in_r     = signed'(req_tdata[31:16]);
   assign is_flush = req_kind_type'(req_tuser[0]) == REQ_FLUSH;
   assign a_free   = !a_vld_ff || out_adv;
   assign issue_go = (cnt_ff != 2'd0) && a_free;
   assign req_tready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && a_free);
   assign accept   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_mode_ff  <= MODE_PASS;
         phase_step_ff <= PHASE_STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_RATE_MODE:  rate_mode_ff  <= rate_mode_type'(csr_wdata[1:0]);
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      ph0 = {2'b00, frac_phase_ff};
      st  = {2'b00, phase_step_ff};
      ph1 = ph0 + st;
      ph2 = ph0 + {st[16:0], 1'b0};
      ph3 = ph2 + st;
      if (ph1 >= PHASE_ONE) begin
         frac_cnt  = 2'd1;
         frac_next = ph1[15:0];
      end else if (ph2 >= PHASE_ONE) begin
         frac_cnt  = 2'd2;
         frac_next = ph2[15:0];
      end else begin
         frac_cnt  = 2'd3;
         frac_next = (ph3 >= PHASE_ONE) ? ph3[15:0] : 16'd0;
      end
   end

   always_comb begin
      int_prev_l_in  = int_prev_l_ff;
      int_prev_r_in  = int_prev_r_ff;
      frac_prev_l_in = frac_prev_l_ff;
      frac_prev_r_in = frac_prev_r_ff;
      frac_phase_in  = frac_phase_ff;
      mode_in        = mode_ff;
      prev_l_in      = prev_l_ff;
      prev_r_in      = prev_r_ff;
      frac_in        = frac_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      if (issue_go) begin
         cnt_in  = cnt_ff - 2'd1;
         idx_in  = idx_ff + 2'd1;
         frac_in = frac_ff + step_ff;
      end
      if (accept) begin
         mode_in = rate_mode_ff;
         idx_in  = 2'd0;
         frac_in = frac_phase_ff;
         if (is_flush) begin
            frac_prev_l_in = '0;
            frac_prev_r_in = '0;
            frac_phase_in  = '0;
            cnt_in         = 2'd0;
         end else begin
            unique case (rate_mode_ff)
               MODE_PASS: begin
                  cnt_in = 2'd1;
               end
               MODE_X3, MODE_X2: begin
                  cnt_in        = (rate_mode_ff == MODE_X3) ? 2'd3 : 2'd2;
                  prev_l_in     = req_tuser[1] ? in_l : int_prev_l_ff;
                  prev_r_in     = req_tuser[1] ? in_r : int_prev_r_ff;
                  int_prev_l_in = in_l;
                  int_prev_r_in = in_r;
               end
               MODE_FRAC: begin
                  cnt_in         = frac_cnt;
                  prev_l_in      = frac_prev_l_ff;
                  prev_r_in      = frac_prev_r_ff;
                  frac_prev_l_in = in_l;
                  frac_prev_r_in = in_r;
                  frac_phase_in  = frac_next;
               end
            endcase
         end
      end
      a_vld_in  = issue_go ? 1'b1 : (out_adv ? 1'b0 : a_vld_ff);
      a_last_in = issue_go ? (cnt_ff == 2'd1) : a_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_prev_l_ff  <= '0;
         int_prev_r_ff  <= '0;
         frac_prev_l_ff <= '0;
         frac_prev_r_ff <= '0;
         frac_phase_ff  <= '0;
         cnt_ff         <= 2'd0;
         a_vld_ff       <= 1'b0;
      end else begin
         int_prev_l_ff  <= int_prev_l_in;
         int_prev_r_ff  <= int_prev_r_in;
         frac_prev_l_ff <= frac_prev_l_in;
         frac_prev_r_ff <= frac_prev_r_in;
         frac_phase_ff  <= frac_phase_in;
         cnt_ff         <= cnt_in;
         a_vld_ff       <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      prev_l_ff <= prev_l_in;
      prev_r_ff <= prev_r_in;
      frac_ff   <= frac_in;
      idx_ff    <= idx_in;
      a_last_ff <= a_last_in;
      if (accept) begin
         cur_l_ff <= in_l;
         cur_r_ff <= in_r;
         step_ff  <= phase_step_ff;
      end
   end

   assign issue = '{mode: mode_ff, idx: idx_ff, frac: frac_ff};

   stu_lane u_lane_l (
      .clock (clock),
      .load  (issue_go),
      .issue (issue),
      .prev  (prev_l_ff),
      .cur   (cur_l_ff),
      .value (lane_l)
   );

   stu_lane u_lane_r (
      .clock (clock),
      .load  (issue_go),
      .issue (issue),
      .prev  (prev_r_ff),
      .cur   (cur_r_ff),
      .value (lane_r)
   );

   stu_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .a_valid    (a_vld_ff),
      .a_last     (a_last_ff),
      .left       (lane_l),
      .right      (lane_r),
      .out_adv    (out_adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && !out_adv) |=> a_vld_ff)
      else $error("lane stage dropped a frame");

   a_flush_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && is_flush) |=> (cnt_ff == 2'd0))
      else $error("flush scheduled results");

   a_frame_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_flush) |=> (cnt_ff != 2'd0))
      else $error("frame scheduled no result");

endmodule
